### rtl/core/vnorm_pkg.sv
// Shared constants and types for the 3D vector normalizer.
// Used by vnorm_root_step and by the vec3_normalize top level.
// Depends on nothing else.
`timescale 1ns / 1ps

package vnorm_pkg;

   // Fixed-point format of the components: Q7.16 at the default width.
   localparam int COMPONENT_WIDTH_DEFAULT = 24;
   localparam int FRAC_BITS               = 16;

   // The square-root search yields an integer of up to 2^(FRAC_BITS+1),
   // so it needs FRAC_BITS+2 result bits, one pipeline stage per bit.
   localparam int ROOT_BITS = FRAC_BITS + 2;

   // Control and status register port.
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ZERO_THRESHOLD = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNIT_TOLERANCE = CSR_INDEX_WIDTH'(1);

   localparam logic [CSR_DATA_WIDTH-1:0] ZERO_THRESHOLD_RESET = 16'd4295;
   localparam logic [CSR_DATA_WIDTH-1:0] UNIT_TOLERANCE_RESET = 16'd4295;

   // What happened to a vector.
   typedef enum logic [1:0] {
      OUTCOME_SCALED = 2'd0,
      OUTCOME_ZERO   = 2'd1,
      OUTCOME_UNIT   = 2'd2
   } outcome_type;

endpackage

### rtl/core/vnorm_root_step.sv
// One bit of the pipelined root search: decides one bit of u = floor(M / sqrt(L)).
// Holds the running remainder M^2 - u^2*L and the product u*L in registers.
// Depends on vnorm_pkg.
`timescale 1ns / 1ps

module vnorm_root_step
   import vnorm_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEFAULT,
   parameter int BIT_POS         = 0
) (
   input  logic                                          clock,
   input  logic                                          enable,
   input  logic [2*COMPONENT_WIDTH-1:0]                  len_sq,
   input  logic [2*COMPONENT_WIDTH+2*FRAC_BITS+1:0]      rem_up,
   input  logic [2*COMPONENT_WIDTH+ROOT_BITS-1:0]        prod_up,
   input  logic [ROOT_BITS-1:0]                          root_up,
   output logic [2*COMPONENT_WIDTH+2*FRAC_BITS+1:0]      rem_dn,
   output logic [2*COMPONENT_WIDTH+ROOT_BITS-1:0]        prod_dn,
   output logic [ROOT_BITS-1:0]                          root_dn
);

   localparam int LW = 2 * COMPONENT_WIDTH;
   localparam int RW = LW + 2 * FRAC_BITS + 2;
   localparam int PW = LW + ROOT_BITS;
   localparam int DW = LW + 2 * ROOT_BITS + 1;

   logic [DW-1:0]        delta;
   logic                 fits;
   logic [RW-1:0]        rem_in;
   logic [PW-1:0]        prod_in;
   logic [ROOT_BITS-1:0] root_in;
   logic [RW-1:0]        rem_ff;
   logic [PW-1:0]        prod_ff;
   logic [ROOT_BITS-1:0] root_ff;

   // Setting bit b raises u^2*L by 2^(b+1)*u*L + 2^(2b)*L.
   always_comb begin
      delta = (DW'(prod_up) << (BIT_POS + 1)) + (DW'(len_sq) << (2 * BIT_POS));
      fits  = DW'(rem_up) >= delta;
   end

   // Keep the bit when the square still fits under M^2.
   always_comb begin
      rem_in  = fits ? (rem_up - delta[RW-1:0]) : rem_up;
      prod_in = fits ? (prod_up + (PW'(len_sq) << BIT_POS)) : prod_up;
      root_in = root_up | ({{(ROOT_BITS-1){1'b0}}, fits} << BIT_POS);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         prod_ff <= prod_in;
         root_ff <= root_in;
      end
   end

   assign rem_dn  = rem_ff;
   assign prod_dn = prod_ff;
   assign root_dn = root_ff;

endmodule

### rtl/core/vec3_normalize.sv
// Top level of the 3D vector normalizer: input skid register, square and sum
// stages, three lanes of vnorm_root_step, rounding and output register.
// Depends on vnorm_pkg and vnorm_root_step.
//
// Usage:
//   A request on req_ carries one vector of three signed Q7.16 components.
//   The result on rsp_ carries the three output components in rsp_tdata and
//   the outcome code in rsp_tuser: scaled to unit length, zero vector kept,
//   or already unit kept. Each request gives exactly one result, in order.
//   The csr_ port writes zero_threshold (index 0) and unit_tolerance
//   (index 1); writes to other indexes are dropped. csr_ready is always high.
//   From request to result the data passes these stages: four
//   stages form magnitudes, squares, the squared length and the range
//   tests, one stage per bit of the 18-bit root search, one output stage.
//   Throughput is one vector per cycle while the output is not held, set
//   by the fully pipelined root search with its own stage per bit and lane.
//   When rsp_tready is low with a result waiting, the whole pipeline holds
//   and one more request is still taken into the skid register; req_tready
//   drops while that register is full. Reset empties the pipeline and the
//   skid register and restores both thresholds to 4295.
`timescale 1ns / 1ps

module vec3_normalize
   import vnorm_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Request channel.
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0]   req_tdata,  // comp_x, comp_y, comp_z
   // Result channel.
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0]   rsp_tdata,  // norm_x, norm_y, norm_z
   output logic [1:0]                               rsp_tuser,  // outcome
   // Register write channel.
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]               csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]                csr_data
);

   localparam int W      = COMPONENT_WIDTH;
   localparam int TW     = ((3 * W + 7) / 8) * 8;
   localparam int VW     = 3 * W;
   localparam int LW     = 2 * W;
   localparam int RW     = LW + 2 * FRAC_BITS + 2;
   localparam int PW     = LW + ROOT_BITS;
   localparam int SW     = ((W > ROOT_BITS) ? W : ROOT_BITS) + 1;
   localparam int NSTAGE = ROOT_BITS + 5;
   localparam int ROOT0  = 4;

   localparam logic [ROOT_BITS-1:0] ROOT_LIMIT = ROOT_BITS'(1) << (ROOT_BITS - 1);

   // ---------------------------------------------------------------------
   // Register port.
   // ---------------------------------------------------------------------
   logic [CSR_DATA_WIDTH-1:0] zero_thr_ff;
   logic [CSR_DATA_WIDTH-1:0] unit_tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_thr_ff <= ZERO_THRESHOLD_RESET;
         unit_tol_ff <= UNIT_TOLERANCE_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_ZERO_THRESHOLD) begin
            zero_thr_ff <= csr_data;
         end
         if (csr_index == REG_UNIT_TOLERANCE) begin
            unit_tol_ff <= csr_data;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: the pipeline moves as one whenever the output is free.
   // ---------------------------------------------------------------------
   logic              adv;
   logic [NSTAGE-1:0] vld_ff;
   logic              skid_full_ff;
   logic              skid_full_in;
   logic [VW-1:0]     skid_data_ff;
   logic              src_valid;
   logic [VW-1:0]     src_data;

   assign adv        = !vld_ff[NSTAGE-1] || rsp_tready;
   assign req_tready = !skid_full_ff;
   assign src_valid  = skid_full_ff || req_tvalid;
   assign src_data   = skid_full_ff ? skid_data_ff : req_tdata[VW-1:0];

   // The skid register catches a request taken while the pipeline holds.
   always_comb begin
      if (skid_full_ff) begin
         skid_full_in = !adv;
      end else begin
         skid_full_in = req_tvalid && !adv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff && req_tvalid && !adv) begin
         skid_data_ff <= req_tdata[VW-1:0];
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], src_valid};
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: sign and magnitude of each component.
   // ---------------------------------------------------------------------
   logic [W-1:0] a_mag_in [3];
   logic [2:0]   a_neg_in;
   logic [VW-1:0] a_raw_ff;
   logic [W-1:0] a_mag_ff [3];
   logic [2:0]   a_neg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_neg_in[i] = src_data[i*W + W - 1];
         a_mag_in[i] = a_neg_in[i] ? (~src_data[i*W +: W] + W'(1)) : src_data[i*W +: W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_raw_ff <= src_data;
         a_neg_ff <= a_neg_in;
         for (int i = 0; i < 3; i++) begin
            a_mag_ff[i] <= a_mag_in[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage B: squares of the magnitudes.
   // ---------------------------------------------------------------------
   logic [VW-1:0] b_raw_ff;
   logic [2:0]    b_neg_ff;
   logic [LW-1:0] b_sq_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         b_raw_ff <= a_raw_ff;
         b_neg_ff <= a_neg_ff;
         for (int i = 0; i < 3; i++) begin
            b_sq_ff[i] <= LW'(a_mag_ff[i]) * LW'(a_mag_ff[i]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage C: squared length in units of 2^-32.
   // ---------------------------------------------------------------------
   logic [VW-1:0] c_raw_ff;
   logic [2:0]    c_neg_ff;
   logic [LW-1:0] c_sq_ff [3];
   logic [LW-1:0] c_len_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         c_raw_ff <= b_raw_ff;
         c_neg_ff <= b_neg_ff;
         c_len_ff <= b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
         for (int i = 0; i < 3; i++) begin
            c_sq_ff[i] <= b_sq_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage D: zero and unit range tests.
   // ---------------------------------------------------------------------
   logic [LW:0]   unit_sq;
   logic [LW:0]   len_ext;
   logic          d_zero_in;
   logic          d_unit_in;
   logic [VW-1:0] d_raw_ff;
   logic [2:0]    d_neg_ff;
   logic [LW-1:0] d_sq_ff [3];
   logic [LW-1:0] d_len_ff;
   logic          d_zero_ff;
   logic          d_unit_ff;

   always_comb begin
      unit_sq   = (LW+1)'(1) << (2 * FRAC_BITS);
      len_ext   = (LW+1)'(c_len_ff);
      d_zero_in = len_ext <= (LW+1)'(zero_thr_ff);
      d_unit_in = (len_ext >= unit_sq - (LW+1)'(unit_tol_ff))
               && (len_ext <= unit_sq + (LW+1)'(unit_tol_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_raw_ff  <= c_raw_ff;
         d_neg_ff  <= c_neg_ff;
         d_len_ff  <= c_len_ff;
         d_zero_ff <= d_zero_in;
         d_unit_ff <= d_unit_in;
         for (int i = 0; i < 3; i++) begin
            d_sq_ff[i] <= c_sq_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Root search: u = floor(mag * 2^17 / sqrt(L)), one bit per stage.
   // ---------------------------------------------------------------------
   logic [LW-1:0]        len_at      [ROOT_BITS];
   logic [LW-1:0]        len_pipe_ff [ROOT_BITS-1];
   logic [RW-1:0]        rem_dn      [3][ROOT_BITS];
   logic [PW-1:0]        prod_dn     [3][ROOT_BITS];
   logic [ROOT_BITS-1:0] root_dn     [3][ROOT_BITS];

   assign len_at[0] = d_len_ff;

   for (genvar s = 0; s < ROOT_BITS - 1; s++) begin : g_len
      always_ff @(posedge clock) begin
         if (adv) begin
            len_pipe_ff[s] <= len_at[s];
         end
      end
      assign len_at[s+1] = len_pipe_ff[s];
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      for (genvar s = 0; s < ROOT_BITS; s++) begin : g_step
         logic [RW-1:0]        rem_up;
         logic [PW-1:0]        prod_up;
         logic [ROOT_BITS-1:0] root_up;

         if (s == 0) begin : g_first
            assign rem_up  = RW'(d_sq_ff[i]) << (2 * FRAC_BITS + 2);
            assign prod_up = '0;
            assign root_up = '0;
         end else begin : g_next
            assign rem_up  = rem_dn[i][s-1];
            assign prod_up = prod_dn[i][s-1];
            assign root_up = root_dn[i][s-1];
         end

         vnorm_root_step #(
            .COMPONENT_WIDTH (COMPONENT_WIDTH),
            .BIT_POS         (ROOT_BITS - 1 - s)
         ) u_step (
            .clock   (clock),
            .enable  (adv),
            .len_sq  (len_at[s]),
            .rem_up  (rem_up),
            .prod_up (prod_up),
            .root_up (root_up),
            .rem_dn  (rem_dn[i][s]),
            .prod_dn (prod_dn[i][s]),
            .root_dn (root_dn[i][s])
         );
      end
   end

   // Pass-through data and flags ride along with the root search.
   logic [VW-1:0] side_raw_ff  [ROOT_BITS];
   logic [2:0]    side_neg_ff  [ROOT_BITS];
   logic          side_zero_ff [ROOT_BITS];
   logic          side_unit_ff [ROOT_BITS];

   always_ff @(posedge clock) begin
      if (adv) begin
         side_raw_ff[0]  <= d_raw_ff;
         side_neg_ff[0]  <= d_neg_ff;
         side_zero_ff[0] <= d_zero_ff;
         side_unit_ff[0] <= d_unit_ff;
         for (int s = 1; s < ROOT_BITS; s++) begin
            side_raw_ff[s]  <= side_raw_ff[s-1];
            side_neg_ff[s]  <= side_neg_ff[s-1];
            side_zero_ff[s] <= side_zero_ff[s-1];
            side_unit_ff[s] <= side_unit_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: round half away from zero, saturate, select, register.
   // ---------------------------------------------------------------------
   logic [ROOT_BITS:0] k_full [3];
   logic [SW-1:0]      k_val  [3];
   logic [SW-1:0]      k_sat  [3];
   logic [SW-1:0]      pos_max;
   logic [SW-1:0]      neg_max;
   logic [W-1:0]       norm_in [3];
   outcome_type        outcome_in;
   logic [W-1:0]       norm_ff [3];
   outcome_type        outcome_ff;

   always_comb begin
      pos_max = (SW'(1) << (W - 1)) - SW'(1);
      neg_max = SW'(1) << (W - 1);
      for (int i = 0; i < 3; i++) begin
         // k = floor((u + 1) / 2) is the rounded quotient.
         k_full[i] = ((ROOT_BITS+1)'(root_dn[i][ROOT_BITS-1]) + (ROOT_BITS+1)'(1)) >> 1;
         k_val[i]  = SW'(k_full[i]);
         if (side_neg_ff[ROOT_BITS-1][i]) begin
            k_sat[i]   = (k_val[i] > neg_max) ? neg_max : k_val[i];
            norm_in[i] = W'(SW'(0) - k_sat[i]);
         end else begin
            k_sat[i]   = (k_val[i] > pos_max) ? pos_max : k_val[i];
            norm_in[i] = W'(k_sat[i]);
         end
         if (side_zero_ff[ROOT_BITS-1] || side_unit_ff[ROOT_BITS-1]) begin
            norm_in[i] = side_raw_ff[ROOT_BITS-1][i*W +: W];
         end
      end
      if (side_zero_ff[ROOT_BITS-1]) begin
         outcome_in = OUTCOME_ZERO;
      end else if (side_unit_ff[ROOT_BITS-1]) begin
         outcome_in = OUTCOME_UNIT;
      end else begin
         outcome_in = OUTCOME_SCALED;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         outcome_ff <= outcome_in;
         for (int i = 0; i < 3; i++) begin
            norm_ff[i] <= norm_in[i];
         end
      end
   end

   assign rsp_tvalid = vld_ff[NSTAGE-1];
   assign rsp_tdata  = TW'({norm_ff[2], norm_ff[1], norm_ff[0]});
   assign rsp_tuser  = outcome_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // The zero and unit ranges never overlap with 16-bit thresholds.
   a_tests_disjoint : assert property (@(posedge clock) disable iff (reset)
      vld_ff[ROOT0-1] |-> !(d_zero_ff && d_unit_ff))
      else $error("zero and unit tests both hit");

   // A vector that is not zero never yields a root above 2^17.
   a_root_bound : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NSTAGE-2] && !side_zero_ff[ROOT_BITS-1]) |->
         ((root_dn[0][ROOT_BITS-1] <= ROOT_LIMIT)
          && (root_dn[1][ROOT_BITS-1] <= ROOT_LIMIT)
          && (root_dn[2][ROOT_BITS-1] <= ROOT_LIMIT)))
      else $error("root search exceeded its bound");

   // The skid register only fills behind a waiting result.
   a_skid_behind_result : assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_tvalid)
      else $error("skid register full without a waiting result");

   // A request taken while the pipeline holds lands in the skid register.
   a_skid_catch : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !adv) |=> skid_full_ff)
      else $error("request taken during hold was not kept");

   // A held pipeline keeps its valid bits.
   a_hold_valid : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid bits moved during hold");

endmodule
